/* hdl/stdt_pkg.sv */
// Shared constants, codes and types for the sprite texel scaler.
package stdt_pkg;

    localparam int TEX_ENTRIES = 4096;
    localparam int TEX_AW      = $clog2(TEX_ENTRIES);
    localparam int COLOR_W     = 24;
    localparam int PADDR_W     = 4;

    // Divider geometry: 7 quotient bits cover every texel coordinate.
    localparam int QUO_W     = 7;
    localparam int DIV_STEPS = QUO_W;
    localparam int DIV_LAT   = DIV_STEPS + 1;
    localparam int NUM_W     = 25;
    localparam int DEN_W     = 17;
    localparam int OFS_W     = 18;
    localparam int IDX_W     = 14;

    localparam logic [11:0] WINDOW_HEIGHT_RST = 12'd600;
    localparam logic [6:0]  TEX_WIDTH_RST     = 7'd64;
    localparam logic [6:0]  TEX_HEIGHT_RST    = 7'd64;

    typedef enum logic [PADDR_W-1:0] {
        REG_WINDOW_HEIGHT = 4'h0,
        REG_TEX_WIDTH     = 4'h4,
        REG_TEX_HEIGHT    = 4'h8
    } t_reg_addr;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_SHADE = 1'b1
    } t_cmd;

    // Per-request data carried alongside the arithmetic.
    typedef struct packed {
        t_cmd                cmd;
        logic                ok;
        logic [10:0]         px;
        logic [10:0]         py;
        logic [TEX_AW-1:0]   addr;
        logic [COLOR_W-1:0]  color;
    } t_side;

    typedef struct packed {
        logic               we;
        logic [10:0]        x;
        logic [10:0]        y;
        logic [COLOR_W-1:0] color;
    } t_rsp;

endpackage

/* hdl/stdt_if.sv */
// Request and response channel interfaces.
interface stdt_req_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [10:0] pixel_x;
    logic [10:0] pixel_y;
    logic [15:0] sprite_w;
    logic [15:0] sprite_h;
    logic signed [15:0] sprite_center_x;
    logic signed [31:0] sprite_depth;
    logic signed [31:0] column_depth;
    logic [11:0] texel_address;
    logic [23:0] texel_color;

    modport source (output valid, command, pixel_x, pixel_y, sprite_w, sprite_h,
                    sprite_center_x, sprite_depth, column_depth, texel_address,
                    texel_color, input ready);
    modport sink (input valid, command, pixel_x, pixel_y, sprite_w, sprite_h,
                  sprite_center_x, sprite_depth, column_depth, texel_address,
                  texel_color, output ready);
endinterface

interface stdt_rsp_if;
    logic        valid;
    logic        ready;
    logic        write_enable;
    logic [10:0] out_x;
    logic [10:0] out_y;
    logic [23:0] out_color;

    modport source (output valid, write_enable, out_x, out_y, out_color, input ready);
    modport sink (input valid, write_enable, out_x, out_y, out_color, output ready);
endinterface

/* hdl/stdt_div.sv */
// Pipelined truncating divider: 7-bit quotient plus an in-range flag.
module stdt_div import stdt_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0]        i_den,
    output logic [QUO_W-1:0]        o_quo,
    output logic                    o_fit
);

    logic [NUM_W-1:0] r_rem [0:DIV_STEPS];
    logic [QUO_W-1:0] r_quo [0:DIV_STEPS];
    logic [DEN_W-1:0] r_den [0:DIV_STEPS];
    logic             r_fit [0:DIV_STEPS];

    logic             neg;
    logic [NUM_W-1:0] mag;
    logic             fit0;

    // Negative numerators truncate to zero when smaller than the divisor.
    always_comb begin
        neg  = i_num[NUM_W-1];
        mag  = neg ? NUM_W'(-i_num) : NUM_W'(i_num);
        fit0 = neg ? (mag < NUM_W'(i_den))
                   : (mag < (NUM_W'(i_den) << QUO_W));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= neg ? '0 : mag;
            r_quo[0] <= '0;
            r_den[0] <= i_den;
            r_fit[0] <= fit0;
        end
    end

    for (genvar s = 1; s <= DIV_STEPS; s++) begin : g_step
        localparam int K = DIV_STEPS - s;
        logic [NUM_W-1:0] sub;
        logic             ge;
        assign sub = NUM_W'(r_den[s-1]) << K;
        assign ge  = r_rem[s-1] >= sub;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= ge ? r_rem[s-1] - sub : r_rem[s-1];
                r_quo[s] <= r_quo[s-1] | (ge ? QUO_W'(1) << K : '0);
                r_den[s] <= r_den[s-1];
                r_fit[s] <= r_fit[s-1];
            end
        end
    end

    assign o_quo = r_quo[DIV_STEPS];
    assign o_fit = r_fit[DIV_STEPS];

endmodule

/* hdl/sprite_texel_scaler_depth_test_unit.sv */
// Sprite texel scaler with depth test: top level.
//
//  channel   | dir | handshake        | content
//  ----------+-----+------------------+---------------------------------------
//  i_req     | in  | valid/ready      | load texel or shade pixel request
//  o_rsp     | out | valid/ready      | pixel write, one per shade request
//  apb       | in  | psel/penable     | window_height, tex_width, tex_height
//
//  One request per cycle while the skid entry is empty; the path from accept to
//  o_rsp.valid runs through the 8-stage texel coordinate divider and the store read.
//  Loads write the store at the same stage where shades read it, so order holds.
//  Reset clears valid bits and config only; the texture store is not cleared.
//  A two-entry output buffer (register plus skid) absorbs a stalled o_rsp;
//  the pipe freezes only once the skid entry is occupied.
module sprite_texel_scaler_depth_test_unit import stdt_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    stdt_req_if.sink           i_req,
    stdt_rsp_if.source         o_rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // ---------------- configuration ----------------
    logic [11:0] r_wh;
    logic [6:0]  r_tw;
    logic [6:0]  r_th;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wh <= WINDOW_HEIGHT_RST;
            r_tw <= TEX_WIDTH_RST;
            r_th <= TEX_HEIGHT_RST;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr)
                REG_WINDOW_HEIGHT: r_wh <= pwdata[11:0];
                REG_TEX_WIDTH:     r_tw <= pwdata[6:0];
                REG_TEX_HEIGHT:    r_th <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr)
            REG_WINDOW_HEIGHT: prdata = {20'd0, r_wh};
            REG_TEX_WIDTH:     prdata = {25'd0, r_tw};
            REG_TEX_HEIGHT:    prdata = {25'd0, r_th};
            default:           prdata = '0;
        endcase
    end

    // ---------------- pipe control ----------------
    logic adv;          // whole pipe advances
    logic r_skid_v;
    assign adv         = !r_skid_v;
    assign i_req.ready = adv;

    // Stage 1: captured request
    logic        r1_v;
    t_side       r1_side;
    logic [15:0] r1_sw, r1_sh;
    logic signed [15:0] r1_cx;
    logic signed [31:0] r1_depth, r1_zcol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else if (adv) r1_v <= i_req.valid;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_side.cmd   <= t_cmd'(i_req.command);
            r1_side.ok    <= 1'b1;
            r1_side.px    <= i_req.pixel_x;
            r1_side.py    <= i_req.pixel_y;
            r1_side.addr  <= i_req.texel_address;
            r1_side.color <= i_req.texel_color;
            r1_sw    <= i_req.sprite_w;
            r1_sh    <= i_req.sprite_h;
            r1_cx    <= i_req.sprite_center_x;
            r1_depth <= i_req.sprite_depth;
            r1_zcol  <= i_req.column_depth;
        end
    end

    // Stage 2: offsets from sprite origin, early rejects
    logic signed [OFS_W-1:0] ofs_x, ofs_y;
    logic                    ok1;
    t_side                   s2_side;

    always_comb begin
        ofs_x = $signed({7'd0, r1_side.px}) - OFS_W'(r1_cx) + $signed({3'd0, r1_sw[15:1]});
        ofs_y = $signed({6'd0, r1_side.py, 1'b0}) - $signed({6'd0, r_wh})
              + $signed({2'd0, r1_sh});
        ok1 = (r1_depth > 0) && (r1_depth < r1_zcol) && (r1_sw != '0) && (r1_sh != '0)
           && (r_tw != '0) && (r_th != '0);
        s2_side    = r1_side;
        s2_side.ok = ok1;
    end

    logic                    r2_v;
    t_side                   r2_side;
    logic signed [OFS_W-1:0] r2_ox, r2_oy;
    logic [15:0]             r2_sw, r2_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else if (adv) r2_v <= r1_v;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_side    <= s2_side;
            r2_ox      <= ofs_x;
            r2_oy      <= ofs_y;
            r2_sw      <= r1_sw;
            r2_sh      <= r1_sh;
        end
    end

    // Stage 3: scale by texture size
    logic signed [OFS_W+7:0] prod_x, prod_y;
    assign prod_x = r2_ox * $signed({1'b0, r_tw});
    assign prod_y = r2_oy * $signed({1'b0, r_th});

    logic                    r3_v;
    t_side                   r3_side;
    logic signed [NUM_W-1:0] r3_nx, r3_ny;
    logic [DEN_W-1:0]        r3_dx, r3_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else if (adv) r3_v <= r2_v;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_side <= r2_side;
            r3_nx   <= NUM_W'(prod_x);
            r3_ny   <= NUM_W'(prod_y);
            r3_dx   <= {1'b0, r2_sw};
            r3_dy   <= {r2_sh, 1'b0};
        end
    end

    // Dividers: tx and ty; side data rides a matching delay line
    logic [QUO_W-1:0] tx, ty;
    logic             fit_x, fit_y;

    stdt_div u_div_x (
        .i_clk (i_clk), .i_en (adv), .i_num (r3_nx), .i_den (r3_dx),
        .o_quo (tx), .o_fit (fit_x)
    );
    stdt_div u_div_y (
        .i_clk (i_clk), .i_en (adv), .i_num (r3_ny), .i_den (r3_dy),
        .o_quo (ty), .o_fit (fit_y)
    );

    logic  r_dl_v [0:DIV_LAT-1];
    t_side r_dl   [0:DIV_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIV_LAT; i++) r_dl_v[i] <= 1'b0;
        end else if (adv) begin
            r_dl_v[0] <= r3_v;
            for (int i = 1; i < DIV_LAT; i++) r_dl_v[i] <= r_dl_v[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dl[0] <= r3_side;
            for (int i = 1; i < DIV_LAT; i++) r_dl[i] <= r_dl[i-1];
        end
    end

    // Stage 4: bounds and store index
    t_side            dl_out;
    logic [IDX_W-1:0] idx;
    logic             ok4;
    t_side            s4_side;

    always_comb begin
        dl_out = r_dl[DIV_LAT-1];
        idx    = IDX_W'(ty) * IDX_W'(r_tw) + IDX_W'(tx);
        ok4    = dl_out.ok && fit_x && fit_y && (tx < r_tw) && (ty < r_th)
              && (idx < IDX_W'(TEX_ENTRIES));
        s4_side    = dl_out;
        s4_side.ok = ok4;
    end

    logic              r4_v;
    t_side             r4_side;
    logic [TEX_AW-1:0] r4_maddr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_v <= 1'b0;
        else if (adv) r4_v <= r_dl_v[DIV_LAT-1];
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r4_side    <= s4_side;
            r4_maddr   <= (dl_out.cmd == CMD_LOAD) ? dl_out.addr : idx[TEX_AW-1:0];
        end
    end

    // Texture store: loads write and shades read at this one stage
    logic [COLOR_W-1:0] mem [0:TEX_ENTRIES-1];
    logic [COLOR_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (adv && r4_v) begin
            if (r4_side.cmd == CMD_LOAD) mem[r4_maddr] <= r4_side.color;
            else                         r_rdata       <= mem[r4_maddr];
        end
    end

    // Stage 5: color key
    logic  r5_v;
    t_side r5_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r5_v <= 1'b0;
        else if (adv) r5_v <= r4_v;
    end

    always_ff @(posedge i_clk) begin
        if (adv) r5_side <= r4_side;
    end

    t_rsp fin;
    logic fin_v;

    always_comb begin
        fin_v     = r5_v && (r5_side.cmd == CMD_SHADE);
        fin.we    = r5_side.ok && (r_rdata != '0);
        fin.x     = r5_side.px;
        fin.y     = r5_side.py;
        fin.color = fin.we ? r_rdata : '0;
    end

    // ---------------- output register + skid ----------------
    logic r_out_v;
    t_rsp r_out, r_skid;
    logic out_take;

    assign out_take = r_out_v && o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (!r_out_v || out_take) begin
                r_out    <= r_skid;
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end
        end else if (fin_v) begin
            if (!r_out_v || out_take) begin
                r_out   <= fin;
                r_out_v <= 1'b1;
            end else begin
                r_skid   <= fin;
                r_skid_v <= 1'b1;
            end
        end else if (out_take) begin
            r_out_v <= 1'b0;
        end
    end

    assign o_rsp.valid        = r_out_v;
    assign o_rsp.write_enable = r_out.we;
    assign o_rsp.out_x        = r_out.x;
    assign o_rsp.out_y        = r_out.y;
    assign o_rsp.out_color    = r_out.color;

    // ---------------- assertions ----------------
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v) else $error("skid entry held with empty output register");

    a_skid_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_out_v && !o_rsp.ready))
        else $error("skid filled without output stall");

    a_nowrite_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !r_out.we) |-> (r_out.color == '0))
        else $error("suppressed write carries color");

    a_write_keyed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out.we) |-> (r_out.color != '0))
        else $error("pixel write with keyed-out color");

endmodule
